>>> hw/rtl/sqv_pkg.sv
// ----------------------------------------------------------------------------
// sqv_pkg
// shared widths, payload structs, controller states and the command and
// status groups between controller and datapath of the square voice
// ----------------------------------------------------------------------------
package sqv_pkg;

    localparam int PHASE_BITS  = 24;
    localparam int LENGTH_BITS = 16;
    localparam int AMP_BITS    = 15;
    localparam int DUTY_BITS   = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int CNT_BITS    = $clog2(PHASE_BITS + 1);

    typedef struct packed {
        logic                   action;
        logic [PHASE_BITS-1:0]  start_step;
        logic [PHASE_BITS-1:0]  end_step;
        logic [DUTY_BITS-1:0]   duty;
        logic [AMP_BITS-1:0]    amplitude;
        logic [LENGTH_BITS-1:0] length;
        logic                   advance_first;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DINIT_STEP,
        S_DRUN_STEP,
        S_DINIT_MAG,
        S_DRUN_MAG,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic latch_note;
        logic load_prod;
        logic div_init_step;
        logic div_init_mag;
        logic div_run;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

>>> hw/rtl/square_voice_sweep_decay.sv
// ----------------------------------------------------------------------------
// square_voice_sweep_decay
// square-wave voice with a linear pitch sweep and a linear amplitude decay
// ----------------------------------------------------------------------------
// A start item is taken while idle and gives no sample. A tick while a note
// plays goes through the states MUL, DINIT_STEP, DRUN_STEP, DINIT_MAG,
// DRUN_MAG and EMIT until the sample sits in the output register: the swept
// phase step and the decay magnitude each go through one shared restoring
// divider that yields one quotient bit per cycle. The next item can transfer
// once the controller is back in idle after a playing tick; while a previous
// sample still waits stalled in the output register, the final step holds.
// A tick while no note plays is taken and gives nothing.
// The input stalls while a tick is in work; a finished sample waits in the
// output register while the next item is taken.
module square_voice_sweep_decay (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sqv_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sqv_pkg::t_out o_out
);

    sqv_pkg::t_cmd    cmd;
    sqv_pkg::t_status status;

    sqv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in.action),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    sqv_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

>>> hw/rtl/sqv_ctrl.sv
// ----------------------------------------------------------------------------
// sqv_ctrl
// controller: accepts items, sequences products, the two serial divisions
// and the sample transfer into the output register
// ----------------------------------------------------------------------------
module sqv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_action,
    input  sqv_pkg::t_status i_status,
    output logic             o_in_stall,
    output sqv_pkg::t_cmd    o_cmd
);

    sqv_pkg::t_state r_state;
    sqv_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sqv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sqv_pkg::S_IDLE: begin
                if (i_in_valid && !i_action && i_status.active) begin
                    n_state = sqv_pkg::S_MUL;
                end
            end
            sqv_pkg::S_MUL:        n_state = sqv_pkg::S_DINIT_STEP;
            sqv_pkg::S_DINIT_STEP: n_state = sqv_pkg::S_DRUN_STEP;
            sqv_pkg::S_DRUN_STEP: begin
                if (i_status.div_last) begin
                    n_state = sqv_pkg::S_DINIT_MAG;
                end
            end
            sqv_pkg::S_DINIT_MAG:  n_state = sqv_pkg::S_DRUN_MAG;
            sqv_pkg::S_DRUN_MAG: begin
                if (i_status.div_last) begin
                    n_state = sqv_pkg::S_EMIT;
                end
            end
            sqv_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = sqv_pkg::S_IDLE;
                end
            end
            default: n_state = sqv_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall          = (r_state != sqv_pkg::S_IDLE);
        o_cmd               = '0;
        o_cmd.latch_note    = (r_state == sqv_pkg::S_IDLE) && i_in_valid && i_action;
        o_cmd.load_prod     = (r_state == sqv_pkg::S_MUL);
        o_cmd.div_init_step = (r_state == sqv_pkg::S_DINIT_STEP);
        o_cmd.div_init_mag  = (r_state == sqv_pkg::S_DINIT_MAG);
        o_cmd.div_run       = (r_state == sqv_pkg::S_DRUN_STEP) ||
                              (r_state == sqv_pkg::S_DRUN_MAG);
        o_cmd.emit          = (r_state == sqv_pkg::S_EMIT) && i_status.out_free;
    end

endmodule

>>> hw/rtl/sqv_dp.sv
// ----------------------------------------------------------------------------
// sqv_dp
// datapath: held note, phase accumulator, sample index, two multipliers,
// a shared restoring divider (one quotient bit per cycle) and output register
// ----------------------------------------------------------------------------
module sqv_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sqv_pkg::t_cmd    i_cmd,
    input  sqv_pkg::t_in     i_in,
    input  logic             i_out_stall,
    output sqv_pkg::t_status o_status,
    output logic             o_out_valid,
    output sqv_pkg::t_out    o_out
);

    localparam int P = sqv_pkg::PHASE_BITS;
    localparam int L = sqv_pkg::LENGTH_BITS;
    localparam int A = sqv_pkg::AMP_BITS;
    localparam int D = sqv_pkg::DUTY_BITS;
    localparam int S = sqv_pkg::SAMPLE_BITS;
    localparam int C = sqv_pkg::CNT_BITS;

    // held note
    logic [P-1:0] r_start;
    logic [P-1:0] r_end;
    logic [D-1:0] r_duty;
    logic [A-1:0] r_amp;
    logic [L-1:0] r_len;
    logic         r_order;

    // voice state
    logic [P-1:0] r_phase;
    logic [L-1:0] r_index;
    logic         r_active;

    // arithmetic
    logic         r_neg;
    logic [P+L-1:0] r_prod_step;
    logic [A+L-1:0] r_prod_mag;
    logic [P-1:0] r_step;
    logic [L-1:0] r_rem;
    logic [P-1:0] r_quo;
    logic [C-1:0] r_cnt;

    logic         r_out_valid;
    sqv_pkg::t_out r_out;

    logic [P-1:0]   diff;
    logic [P+L-1:0] n_prod_step;
    logic [A+L-1:0] n_prod_mag;
    logic [L:0]     trial;
    logic [L:0]     trial_sub;
    logic [L-1:0]   n_rem;
    logic [P-1:0]   n_step;
    logic [P-1:0]   phase_sum;
    logic           high;
    logic [A-1:0]   mag;
    logic [S-1:0]   mag_ext;
    logic [L:0]     index_inc;
    logic           last;
    logic           out_free;

    always_comb begin
        diff        = (r_end < r_start) ? (r_start - r_end) : (r_end - r_start);
        n_prod_step = diff * r_index;
        n_prod_mag  = r_amp * (r_len - r_index);
        trial       = {r_rem, r_quo[P-1]};
        trial_sub   = trial - {1'b0, r_len};
        n_rem       = (trial >= {1'b0, r_len}) ? trial_sub[L-1:0] : trial[L-1:0];
        n_step      = r_neg ? (r_start - r_quo) : (r_start + r_quo);
        phase_sum   = r_phase + r_step;
        high        = r_order ? (phase_sum[P-1 -: D] < r_duty)
                              : (r_phase[P-1 -: D] < r_duty);
        mag         = r_quo[A-1:0];
        mag_ext     = {{(S-A){1'b0}}, mag};
        index_inc   = {1'b0, r_index} + {{L{1'b0}}, 1'b1};
        last        = (index_inc == {1'b0, r_len});
        out_free    = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_end    <= '0;
            r_duty   <= '0;
            r_amp    <= '0;
            r_len    <= {{(L-1){1'b0}}, 1'b1};
            r_order  <= 1'b0;
            r_phase  <= '0;
            r_index  <= '0;
            r_active <= 1'b0;
        end else if (i_cmd.latch_note) begin
            r_start  <= i_in.start_step;
            r_end    <= i_in.end_step;
            r_duty   <= i_in.duty;
            r_amp    <= i_in.amplitude;
            r_len    <= i_in.length;
            r_order  <= i_in.advance_first;
            r_phase  <= '0;
            r_index  <= '0;
            r_active <= (i_in.length != '0);
        end else if (i_cmd.emit) begin
            r_phase <= phase_sum;
            r_index <= index_inc[L-1:0];
            if (last) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_prod) begin
            r_neg       <= (r_end < r_start);
            r_prod_step <= n_prod_step;
            r_prod_mag  <= n_prod_mag;
        end
        if (i_cmd.div_init_step) begin
            r_rem <= r_prod_step[P+L-1:P];
            r_quo <= r_prod_step[P-1:0];
            r_cnt <= C'(P);
        end else if (i_cmd.div_init_mag) begin
            r_step <= n_step;
            r_rem  <= r_prod_mag[A+L-1:A];
            r_quo  <= {r_prod_mag[A-1:0], {(P-A){1'b0}}};
            r_cnt  <= C'(A);
        end else if (i_cmd.div_run) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[P-2:0], (trial >= {1'b0, r_len})};
            r_cnt <= r_cnt - {{(C-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.sample <= high ? mag_ext : (S'(0) - mag_ext);
            r_out.last   <= last;
        end
    end

    assign o_status.active   = r_active;
    assign o_status.div_last = (r_cnt == {{(C-1){1'b0}}, 1'b1});
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

    a_index_in_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_index < r_len))
        else $error("sample index reached note length while active");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_len != '0))
        else $error("active voice with zero length");

    a_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_run |-> (r_rem < r_len))
        else $error("divider remainder not below divisor");

    a_mag_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (mag <= r_amp))
        else $error("decay magnitude above amplitude");

endmodule
